// ===== hw/rtl/jctg_pkg.sv =====
// Shared types, codes and constants of the joint cosine trajectory generator.
// No dependencies; every other RTL file of the block imports this package.
package jctg_pkg;

   localparam int JOINT_COUNT = 16;
   localparam int JOINT_AW    = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

   // Constants of the quarter-wave series: pi/2 and one in Q30, a quarter turn in phase units
   localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
   localparam logic [32:0] ONE_Q30      = 33'd1073741824;
   localparam logic [14:0] QUARTER_TURN = 15'd16384;

   // Rounding divisors of the linear profile
   localparam logic [39:0] MILLI_Q30_DEN  = 40'd1073741824000;
   localparam logic [63:0] MILLI_Q30_HALF = 64'd536870912000;
   localparam logic [39:0] MILLI_DEN      = 40'd1000;
   localparam logic [63:0] MILLI_HALF     = 64'd500;

   typedef enum logic [1:0] {
      OP_START_TARGET,
      OP_START_MAG,
      OP_STOP,
      OP_UPDATE
   } op_type;

   typedef enum logic [1:0] {
      MODE_RAMP,
      MODE_SINE,
      MODE_LINEAR,
      MODE_NONE
   } mode_type;

   typedef enum logic [1:0] {
      DEN_HALF,
      DEN_ONE,
      DEN_MILLI_Q30,
      DEN_MILLI
   } den_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DECIDE,
      ST_PHASE,
      ST_QX,
      ST_QX2,
      ST_QT,
      ST_QTD,
      ST_TRIG,
      ST_SCALE,
      ST_ROUND,
      ST_APPLY,
      ST_RESP
   } state_type;

   // Write beat into the joint store
   typedef struct packed {
      logic                base;    // start time, start position, velocity
      logic                prof;    // magnitude and period
      logic                tpos;    // target position
      logic [JOINT_AW-1:0] idx;
      logic [31:0]         time_v;
      logic [31:0]         spos;
      logic [31:0]         mag;
      logic [15:0]         per;
      logic [31:0]         tpos_v;
      logic [31:0]         tvel;
   } store_wr_type;

   typedef struct packed {
      logic [31:0] time_v;
      logic [31:0] spos;
      logic [31:0] mag;
      logic [15:0] per;
      logic [31:0] tpos;
      logic [31:0] tvel;
   } record_type;

   // Divisor (2k)(2k+1) of Taylor term k, with k = sel + 1
   function automatic logic [39:0] taylor_div(input logic [1:0] sel);
      logic [39:0] d;
      case (sel)
         2'd0:    d = 40'd6;
         2'd1:    d = 40'd20;
         2'd2:    d = 40'd42;
         default: d = 40'd72;
      endcase
      return d;
   endfunction

endpackage

// ===== hw/rtl/jctg_mul_serial.sv =====
// Shift-add multiplier, one multiplier bit per cycle, 32 x 32 -> 64 unsigned.
// Depends on jctg_pkg.
module jctg_mul_serial
   import jctg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic        done,
   output logic [63:0] prod
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] a_ff, a_in;
   logic [63:0] prod_ff, prod_in;
   logic [32:0] sum;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Operand and product shift register
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      prod_ff <= prod_in;
   end

   // Add multiplicand into the upper half, shift one bit right
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      prod_in = prod_ff;
      sum     = {1'b0, prod_ff[63:32]} + {1'b0, (prod_ff[0] ? a_ff : 32'd0)};
      if (start) begin
         a_in    = a;
         prod_in = {32'd0, b};
         cnt_in  = 5'd0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         prod_in = {sum, prod_ff[31:1]};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

// ===== hw/rtl/jctg_div_serial.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend, 40-bit divisor.
// Depends on jctg_pkg.
module jctg_div_serial
   import jctg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [39:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [39:0] den_ff, den_in;
   logic [39:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [40:0] trial;
   logic [40:0] diff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Remainder and quotient shift registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // Shift in one dividend bit, subtract where the divisor fits
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[63]};
      diff    = trial - {1'b0, den_ff};
      if (start) begin
         den_in = divisor;
         rem_in = 40'd0;
         quo_in = dividend;
         cnt_in = 6'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[40]) begin
            rem_in = diff[39:0];
         end else begin
            rem_in = trial[39:0];
         end
         quo_in = {quo_ff[62:0], ~diff[40]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/jctg_joint_store.sv =====
// Per-joint trajectory records with reset values, one write beat per cycle.
// Depends on jctg_pkg.
module jctg_joint_store
   import jctg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  store_wr_type        wr,
   input  logic [JOINT_AW-1:0] rd_idx,
   output record_type          rd
);

   logic [31:0] time_ff [JOINT_COUNT];
   logic [31:0] spos_ff [JOINT_COUNT];
   logic [31:0] mag_ff  [JOINT_COUNT];
   logic [15:0] per_ff  [JOINT_COUNT];
   logic [31:0] tpos_ff [JOINT_COUNT];
   logic [31:0] tvel_ff [JOINT_COUNT];

   // Reset records to zero with a period of one, write the addressed joint
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < JOINT_COUNT; j++) begin
            time_ff[j] <= 32'd0;
            spos_ff[j] <= 32'd0;
            mag_ff[j]  <= 32'd0;
            per_ff[j]  <= 16'd1;
            tpos_ff[j] <= 32'd0;
            tvel_ff[j] <= 32'd0;
         end
      end else begin
         if (wr.base) begin
            time_ff[wr.idx] <= wr.time_v;
            spos_ff[wr.idx] <= wr.spos;
            tvel_ff[wr.idx] <= wr.tvel;
         end
         if (wr.prof) begin
            mag_ff[wr.idx] <= wr.mag;
            per_ff[wr.idx] <= wr.per;
         end
         if (wr.tpos) begin
            tpos_ff[wr.idx] <= wr.tpos_v;
         end
      end
   end

   // Read the addressed joint
   always_comb begin
      rd.time_v = time_ff[rd_idx];
      rd.spos   = spos_ff[rd_idx];
      rd.mag    = mag_ff[rd_idx];
      rd.per    = per_ff[rd_idx];
      rd.tpos   = tpos_ff[rd_idx];
      rd.tvel   = tvel_ff[rd_idx];
   end

endmodule

// ===== hw/rtl/joint_cosine_trajectory_generator_unit.sv =====
// Joint cosine trajectory generator: top level with the command sequencer.
// Depends on jctg_pkg, jctg_joint_store, jctg_mul_serial and jctg_div_serial.
//
// Usage: raise start with a command beat on the req_ ports while busy is low;
// the beat is taken at that edge and busy rises until the result is given.
// Each command yields one result beat on the rsp_ ports, marked by rsp_valid
// for exactly one cycle; the receiver cannot stall it.
// Start and stop are executed in the load state and answered from the
// response state; an unused mode or a finished ramp passes through the
// decide state, and the linear tail runs one divide to round. A profile
// update runs the phase divide, the quarter-wave series (four multiply/divide
// pairs) and the magnitude scaling through one shared bit-serial multiplier
// and one bit-serial divider; the linear head adds a divide to round. One
// command is in work at a time and busy drops in the idle state after the
// result beat, so a new beat can be taken only once the command before it
// has given its result.
// Reset is synchronous: all joint records return to zero with a period of
// one millisecond, and the sequencer returns to idle at once.
module joint_cosine_trajectory_generator_unit
   import jctg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [3:0]         req_joint_index,
   input  logic [1:0]         req_profile_mode,
   input  logic [31:0]        req_now_ms,
   input  logic signed [31:0] req_position_now,
   input  logic signed [31:0] req_velocity_now,
   input  logic signed [31:0] req_target_or_magnitude,
   input  logic [15:0]        req_period_ms,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_desired_position,
   output logic signed [31:0] rsp_desired_velocity,
   output logic               rsp_in_progress,
   output logic               rsp_drive_cleared
);

   state_type   state_ff, state_in;
   logic        go_ff, go_in;
   op_type      op_ff, op_in;
   mode_type    mode_ff, mode_in;
   logic [3:0]  jx_ff, jx_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] posn_ff, posn_in;
   logic [31:0] veln_ff, veln_in;
   logic [31:0] tom_ff, tom_in;
   logic [15:0] per_ff, per_in;

   logic [31:0] e_ff, e_in;
   logic [15:0] pp_ff, pp_in;
   logic [31:0] mag_ff, mag_in;
   logic [31:0] sp_ff, sp_in;
   logic [31:0] tp_ff, tp_in;
   logic [4:0]  kshift_ff, kshift_in;
   logic        cos_ff, cos_in;
   den_type     den_ff, den_in;
   logic [14:0] u_ff, u_in;
   logic        neg_ff, neg_in;
   logic [30:0] x_ff, x_in;
   logic [31:0] x2_ff, x2_in;
   logic [31:0] term_ff, term_in;
   logic signed [33:0] sum_ff, sum_in;
   logic [1:0]  k_ff, k_in;
   logic [32:0] tv_ff, tv_in;
   logic        psign_ff, psign_in;
   logic [63:0] prod_ff, prod_in;
   logic [32:0] q_ff, q_in;
   logic [31:0] out_pos_ff, out_pos_in;
   logic [31:0] out_vel_ff, out_vel_in;
   logic        inprog_ff, inprog_in;
   logic        cleared_ff, cleared_in;

   store_wr_type wr;
   record_type   rec;
   logic         mul_start, mul_done;
   logic [31:0]  mul_a, mul_b;
   logic [63:0]  mul_prod;
   logic         div_start, div_done;
   logic [63:0]  div_dividend, div_quo;
   logic [39:0]  div_divisor;

   logic        jx_ok;
   logic [32:0] mag_diff;
   logic [31:0] absmag;
   logic [31:0] abstv;
   logic [15:0] phase;
   logic [30:0] qv;
   logic [32:0] trig;
   logic [63:0] rnd_sum;
   logic [34:0] sq;
   logic [34:0] base;
   logic [34:0] res;
   logic [31:0] new_pos;

   function automatic logic [31:0] sat32(input logic signed [34:0] v);
      logic [31:0] r;
      if (v > 35'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -35'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   jctg_joint_store u_store (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .rd_idx (JOINT_AW'(jx_ff)),
      .rd     (rec)
   );

   jctg_mul_serial u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   jctg_div_serial u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
      end
   end

   // Command and working registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      mode_ff    <= mode_in;
      jx_ff      <= jx_in;
      now_ff     <= now_in;
      posn_ff    <= posn_in;
      veln_ff    <= veln_in;
      tom_ff     <= tom_in;
      per_ff     <= per_in;
      e_ff       <= e_in;
      pp_ff      <= pp_in;
      mag_ff     <= mag_in;
      sp_ff      <= sp_in;
      tp_ff      <= tp_in;
      kshift_ff  <= kshift_in;
      cos_ff     <= cos_in;
      den_ff     <= den_in;
      u_ff       <= u_in;
      neg_ff     <= neg_in;
      x_ff       <= x_in;
      x2_ff      <= x2_in;
      term_ff    <= term_in;
      sum_ff     <= sum_in;
      k_ff       <= k_in;
      tv_ff      <= tv_in;
      psign_ff   <= psign_in;
      prod_ff    <= prod_in;
      q_ff       <= q_in;
      out_pos_ff <= out_pos_in;
      out_vel_ff <= out_vel_in;
      inprog_ff  <= inprog_in;
      cleared_ff <= cleared_in;
   end

   // Datapath helpers
   always_comb begin
      jx_ok    = ({28'd0, jx_ff} < 32'(JOINT_COUNT));
      mag_diff = {tom_ff[31], tom_ff} - {posn_ff[31], posn_ff};
      absmag   = mag_ff[31] ? (~mag_ff + 32'd1) : mag_ff;
      abstv    = tv_ff[32] ? 32'(~tv_ff + 33'd1) : tv_ff[31:0];
      phase    = div_quo[15:0] + (cos_ff ? 16'h4000 : 16'h0000);
      if (sum_ff[33]) begin
         qv = 31'd0;
      end else if (sum_ff > 34'sd1073741824) begin
         qv = 31'(ONE_Q30);
      end else begin
         qv = sum_ff[30:0];
      end
      trig     = neg_ff ? (~{2'b00, qv} + 33'd1) : {2'b00, qv};
      rnd_sum  = prod_ff + ((den_ff == DEN_HALF) ? 64'h4000_0000 : 64'h2000_0000);
      sq       = psign_ff ? (~{2'b00, q_ff} + 35'd1) : {2'b00, q_ff};
      base     = (mode_ff == MODE_LINEAR) ? {{3{tp_ff[31]}}, tp_ff}
                                          : {{3{sp_ff[31]}}, sp_ff};
      res      = (mode_ff == MODE_SINE) ? (base - sq) : (base + sq);
      new_pos  = sat32($signed(res));
   end

   // Next state, unit launches and store writes
   always_comb begin
      state_in   = state_ff;
      go_in      = go_ff;
      op_in      = op_ff;
      mode_in    = mode_ff;
      jx_in      = jx_ff;
      now_in     = now_ff;
      posn_in    = posn_ff;
      veln_in    = veln_ff;
      tom_in     = tom_ff;
      per_in     = per_ff;
      e_in       = e_ff;
      pp_in      = pp_ff;
      mag_in     = mag_ff;
      sp_in      = sp_ff;
      tp_in      = tp_ff;
      kshift_in  = kshift_ff;
      cos_in     = cos_ff;
      den_in     = den_ff;
      u_in       = u_ff;
      neg_in     = neg_ff;
      x_in       = x_ff;
      x2_in      = x2_ff;
      term_in    = term_ff;
      sum_in     = sum_ff;
      k_in       = k_ff;
      tv_in      = tv_ff;
      psign_in   = psign_ff;
      prod_in    = prod_ff;
      q_in       = q_ff;
      out_pos_in = out_pos_ff;
      out_vel_in = out_vel_ff;
      inprog_in  = inprog_ff;
      cleared_in = cleared_ff;

      wr           = '0;
      wr.idx       = JOINT_AW'(jx_ff);
      mul_start    = 1'b0;
      mul_a        = 32'd0;
      mul_b        = 32'd0;
      div_start    = 1'b0;
      div_dividend = 64'd0;
      div_divisor  = 40'd1;

      unique case (state_ff)
         // Take a command beat
         ST_IDLE: begin
            if (start) begin
               op_in      = op_type'(req_operation);
               mode_in    = mode_type'(req_profile_mode);
               jx_in      = req_joint_index;
               now_in     = req_now_ms;
               posn_in    = req_position_now;
               veln_in    = req_velocity_now;
               tom_in     = req_target_or_magnitude;
               per_in     = req_period_ms;
               inprog_in  = 1'b0;
               cleared_in = 1'b0;
               state_in   = ST_LOAD;
            end
         end

         // Execute start and stop, fetch the record for an update
         ST_LOAD: begin
            if (!jx_ok) begin
               out_pos_in = 32'd0;
               out_vel_in = 32'd0;
               state_in   = ST_RESP;
            end else begin
               unique case (op_ff) inside
                  OP_START_TARGET, OP_START_MAG: begin
                     wr.base    = 1'b1;
                     wr.prof    = 1'b1;
                     wr.tpos    = 1'b1;
                     wr.time_v  = now_ff;
                     wr.spos    = posn_ff;
                     wr.tpos_v  = posn_ff;
                     wr.tvel    = veln_ff;
                     wr.mag     = (op_ff == OP_START_TARGET)
                                  ? sat32($signed({{2{mag_diff[32]}}, mag_diff}))
                                  : tom_ff;
                     wr.per     = (per_ff == 16'd0) ? 16'd1 : per_ff;
                     out_pos_in = posn_ff;
                     out_vel_in = veln_ff;
                     state_in   = ST_RESP;
                  end
                  OP_STOP: begin
                     wr.base    = 1'b1;
                     wr.tpos    = 1'b1;
                     wr.time_v  = now_ff;
                     wr.spos    = posn_ff;
                     wr.tpos_v  = posn_ff;
                     wr.tvel    = 32'd0;
                     out_pos_in = posn_ff;
                     out_vel_in = 32'd0;
                     cleared_in = 1'b1;
                     state_in   = ST_RESP;
                  end
                  default: begin
                     e_in       = now_ff - rec.time_v;
                     pp_in      = rec.per;
                     mag_in     = rec.mag;
                     sp_in      = rec.spos;
                     tp_in      = rec.tpos;
                     out_pos_in = rec.tpos;
                     out_vel_in = rec.tvel;
                     state_in   = ST_DECIDE;
                  end
               endcase
            end
         end

         // Choose the profile segment
         ST_DECIDE: begin
            go_in = 1'b1;
            unique case (mode_ff)
               MODE_RAMP: begin
                  if (e_ff < {16'd0, pp_ff}) begin
                     kshift_in = 5'd15;
                     cos_in    = 1'b1;
                     den_in    = DEN_HALF;
                     inprog_in = 1'b1;
                     state_in  = ST_PHASE;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
               MODE_SINE: begin
                  if ({e_ff, 2'b00} < {18'd0, pp_ff}) begin
                     kshift_in = 5'd17;
                     cos_in    = 1'b1;
                     den_in    = DEN_HALF;
                  end else begin
                     kshift_in = 5'd16;
                     cos_in    = 1'b0;
                     den_in    = DEN_ONE;
                  end
                  state_in = ST_PHASE;
               end
               MODE_LINEAR: begin
                  if ({e_ff, 1'b0} < {17'd0, pp_ff}) begin
                     kshift_in = 5'd16;
                     cos_in    = 1'b1;
                     den_in    = DEN_MILLI_Q30;
                     state_in  = ST_PHASE;
                  end else begin
                     prod_in  = {32'd0, absmag};
                     psign_in = mag_ff[31];
                     den_in   = DEN_MILLI;
                     state_in = ST_ROUND;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         // Phase = floor(e * 2^k / period), folded to a quarter wave
         ST_PHASE: begin
            if (go_ff) begin
               div_start    = 1'b1;
               div_dividend = {32'd0, e_ff} << kshift_ff;
               div_divisor  = {24'd0, pp_ff};
               go_in        = 1'b0;
            end else if (div_done) begin
               u_in     = phase[14] ? (QUARTER_TURN - {1'b0, phase[13:0]})
                                    : {1'b0, phase[13:0]};
               neg_in   = phase[15];
               go_in    = 1'b1;
               state_in = ST_QX;
            end
         end

         // x = u * pi/2 / 2^14
         ST_QX: begin
            if (go_ff) begin
               mul_start = 1'b1;
               mul_a     = {17'd0, u_ff};
               mul_b     = HALF_PI_Q30;
               go_in     = 1'b0;
            end else if (mul_done) begin
               x_in     = mul_prod[44:14];
               go_in    = 1'b1;
               state_in = ST_QX2;
            end
         end

         // x2 = x * x / 2^30, seed the series
         ST_QX2: begin
            if (go_ff) begin
               mul_start = 1'b1;
               mul_a     = {1'b0, x_ff};
               mul_b     = {1'b0, x_ff};
               go_in     = 1'b0;
            end else if (mul_done) begin
               x2_in    = mul_prod[61:30];
               term_in  = {1'b0, x_ff};
               sum_in   = $signed({3'b000, x_ff});
               k_in     = 2'd0;
               go_in    = 1'b1;
               state_in = ST_QT;
            end
         end

         // term = term * x2 / 2^30
         ST_QT: begin
            if (go_ff) begin
               mul_start = 1'b1;
               mul_a     = term_ff;
               mul_b     = x2_ff;
               go_in     = 1'b0;
            end else if (mul_done) begin
               term_in  = mul_prod[61:30];
               go_in    = 1'b1;
               state_in = ST_QTD;
            end
         end

         // term /= (2k)(2k+1), accumulate with alternating sign
         ST_QTD: begin
            if (go_ff) begin
               div_start    = 1'b1;
               div_dividend = {32'd0, term_ff};
               div_divisor  = taylor_div(k_ff);
               go_in        = 1'b0;
            end else if (div_done) begin
               term_in = div_quo[31:0];
               if (k_ff[0]) begin
                  sum_in = sum_ff + $signed({2'b00, div_quo[31:0]});
               end else begin
                  sum_in = sum_ff - $signed({2'b00, div_quo[31:0]});
               end
               go_in = 1'b1;
               if (k_ff == 2'd3) begin
                  state_in = ST_TRIG;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_QT;
               end
            end
         end

         // Clamp, apply quadrant sign, form 1 - cos where needed
         ST_TRIG: begin
            tv_in    = cos_ff ? (ONE_Q30 - trig) : trig;
            go_in    = 1'b1;
            state_in = ST_SCALE;
         end

         // |magnitude| * |trig value|
         ST_SCALE: begin
            if (go_ff) begin
               mul_start = 1'b1;
               mul_a     = absmag;
               mul_b     = abstv;
               psign_in  = mag_ff[31] ^ tv_ff[32];
               go_in     = 1'b0;
            end else if (mul_done) begin
               prod_in  = mul_prod;
               go_in    = 1'b1;
               state_in = ST_ROUND;
            end
         end

         // Round half away from zero on the magnitude
         ST_ROUND: begin
            unique case (den_ff)
               DEN_HALF: begin
                  q_in     = rnd_sum[63:31];
                  state_in = ST_APPLY;
               end
               DEN_ONE: begin
                  q_in     = rnd_sum[62:30];
                  state_in = ST_APPLY;
               end
               default: begin
                  if (go_ff) begin
                     div_start = 1'b1;
                     if (den_ff == DEN_MILLI_Q30) begin
                        div_dividend = prod_ff + MILLI_Q30_HALF;
                        div_divisor  = MILLI_Q30_DEN;
                     end else begin
                        div_dividend = prod_ff + MILLI_HALF;
                        div_divisor  = MILLI_DEN;
                     end
                     go_in = 1'b0;
                  end else if (div_done) begin
                     q_in     = div_quo[32:0];
                     state_in = ST_APPLY;
                  end
               end
            endcase
         end

         // Add or subtract, saturate, write back the target
         ST_APPLY: begin
            wr.tpos    = 1'b1;
            wr.tpos_v  = new_pos;
            out_pos_in = new_pos;
            go_in      = 1'b0;
            state_in   = ST_RESP;
         end

         // Present the result beat
         ST_RESP: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = (state_ff == ST_RESP);
   assign rsp_desired_position = out_pos_ff;
   assign rsp_desired_velocity = out_vel_ff;
   assign rsp_in_progress      = inprog_ff;
   assign rsp_drive_cleared    = cleared_ff;

   // A result beat only while a command is in work
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat outside a command");

   // Taking a command raises busy
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after command");

   // One result beat per command
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat repeated");

   // Stop reports zero velocity and no ramp in progress
   a_stop_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drive_cleared) |-> (rsp_desired_velocity == 32'sd0 && !rsp_in_progress))
      else $error("stop result inconsistent");

endmodule

// ===== bench/tb_joint_cosine_trajectory_generator_unit.sv =====
// Self-checking testbench of the joint cosine trajectory generator unit.
// Depends on jctg_pkg and the unit's RTL; an in-bench predictor of the joint
// records and profiles supplies the expected beats.
module tb_joint_cosine_trajectory_generator_unit;
   import jctg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Q30        = 64'sd1073741824;
   localparam longint HALF_PI    = 64'sd1686629713;
   localparam int     TIMEOUT_NS = 50_000_000;

   typedef struct {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic               in_progress;
      logic               drive_cleared;
   } setpoint_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_operation;
   logic [3:0]         req_joint_index;
   logic [1:0]         req_profile_mode;
   logic [31:0]        req_now_ms;
   logic signed [31:0] req_position_now;
   logic signed [31:0] req_velocity_now;
   logic signed [31:0] req_target_or_magnitude;
   logic [15:0]        req_period_ms;
   logic               rsp_valid;
   logic signed [31:0] rsp_desired_position;
   logic signed [31:0] rsp_desired_velocity;
   logic               rsp_in_progress;
   logic               rsp_drive_cleared;

   // Predictor copy of the joint records
   logic [31:0]  jt_start_time [JOINT_COUNT];
   longint       jt_start_pos  [JOINT_COUNT];
   longint       jt_magnitude  [JOINT_COUNT];
   logic [15:0]  jt_period     [JOINT_COUNT];
   longint       jt_target_pos [JOINT_COUNT];
   longint       jt_target_vel [JOINT_COUNT];

   setpoint_type pending_setpoints[$];
   int           error_count;
   bit           no_idle;

   joint_cosine_trajectory_generator_unit dut (.*);

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // ---------------- fixed-point profile arithmetic ----------------

   function automatic longint sat_q16(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint round_div(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   // Taylor series of sine over one quarter turn, Q30
   function automatic longint quarter_wave(int unsigned u);
      longint x, x2, term, sum;
      x = (longint'(u) * HALF_PI) >>> 14;
      x2 = (x * x) / Q30;
      term = x;
      sum = x;
      for (int k = 1; k <= 4; k++) begin
         term = (term * x2) / Q30;
         term = term / longint'((2 * k) * (2 * k + 1));
         sum = (k % 2 == 1) ? sum - term : sum + term;
      end
      if (sum < 0) sum = 0;
      if (sum > Q30) sum = Q30;
      return sum;
   endfunction

   function automatic longint sine_q30(logic [15:0] p);
      longint v;
      v = p[14] ? quarter_wave(16384 - 32'(p[13:0])) : quarter_wave(32'(p[13:0]));
      return p[15] ? -v : v;
   endfunction

   function automatic longint cosine_q30(logic [15:0] p);
      return sine_q30(p + 16'd16384);
   endfunction

   function automatic logic [15:0] phase_word(logic [31:0] e, int k, logic [15:0] per);
      logic [63:0] num;
      num = {32'd0, e} << k;
      return 16'(num / per);
   endfunction

   // Apply one command to the records and return the beat it yields
   function automatic setpoint_type predict_setpoint(
      op_type op, int j, mode_type mode, logic [31:0] now,
      logic signed [31:0] pos, logic signed [31:0] vel,
      logic signed [31:0] tom, logic [15:0] per_in);
      setpoint_type sp;
      logic [15:0]  per;
      logic [31:0]  e;
      longint       oc, inc;
      sp.in_progress = 1'b0;
      sp.drive_cleared = 1'b0;
      per = (per_in == 0) ? 16'd1 : per_in;
      case (op)
         OP_START_TARGET, OP_START_MAG: begin
            jt_start_time[j] = now;
            jt_start_pos[j] = longint'(pos);
            jt_target_pos[j] = longint'(pos);
            jt_target_vel[j] = longint'(vel);
            jt_magnitude[j] = (op == OP_START_TARGET) ?
                              sat_q16(longint'(tom) - longint'(pos)) : longint'(tom);
            jt_period[j] = per;
         end
         OP_STOP: begin
            jt_start_time[j] = now;
            jt_start_pos[j] = longint'(pos);
            jt_target_pos[j] = longint'(pos);
            jt_target_vel[j] = 0;
            sp.drive_cleared = 1'b1;
         end
         default: begin
            e = now - jt_start_time[j];
            case (mode)
               MODE_RAMP: begin
                  if (e < jt_period[j]) begin
                     oc = Q30 - cosine_q30(phase_word(e, 15, jt_period[j]));
                     jt_target_pos[j] = sat_q16(jt_start_pos[j] +
                                        round_div(jt_magnitude[j] * oc, 2 * Q30));
                     sp.in_progress = 1'b1;
                  end
               end
               MODE_SINE: begin
                  if ({2'b0, e, 2'b0} < {18'd0, jt_period[j]}) begin
                     oc = Q30 - cosine_q30(phase_word(e, 17, jt_period[j]));
                     jt_target_pos[j] = sat_q16(jt_start_pos[j] -
                                        round_div(jt_magnitude[j] * oc, 2 * Q30));
                  end else begin
                     jt_target_pos[j] = sat_q16(jt_start_pos[j] - round_div(
                        jt_magnitude[j] * sine_q30(phase_word(e, 16, jt_period[j])), Q30));
                  end
               end
               MODE_LINEAR: begin
                  if ({1'b0, e, 1'b0} < {17'd0, jt_period[j]}) begin
                     oc = Q30 - cosine_q30(phase_word(e, 16, jt_period[j]));
                     inc = round_div(jt_magnitude[j] * oc, 1000 * Q30);
                  end else begin
                     inc = round_div(jt_magnitude[j], 1000);
                  end
                  jt_target_pos[j] = sat_q16(jt_target_pos[j] + inc);
               end
               default: ;
            endcase
         end
      endcase
      sp.position = jt_target_pos[j][31:0];
      sp.velocity = jt_target_vel[j][31:0];
      return sp;
   endfunction

   // ---------------- driving ----------------

   // Drive one command beat, wait for it to be taken, then idle for a random gap, which may be none
   task automatic send_command(op_type op, int j, mode_type mode, logic [31:0] now,
                               logic signed [31:0] pos, logic signed [31:0] vel,
                               logic signed [31:0] tom, logic [15:0] per);
      int r, gap;
      @(negedge clock);
      start = 1'b1;
      req_operation = op;
      req_joint_index = j[3:0];
      req_profile_mode = mode;
      req_now_ms = now;
      req_position_now = pos;
      req_velocity_now = vel;
      req_target_or_magnitude = tom;
      req_period_ms = per;
      do @(posedge clock); while (busy);
      pending_setpoints.push_back(predict_setpoint(op, j, mode, now, pos, vel, tom, per));
      r = $urandom_range(0, 99);
      if (no_idle) gap = 0;
      else if (r < 70) gap = $urandom_range(0, 3);
      else if (r < 95) gap = $urandom_range(4, 20);
      else gap = $urandom_range(50, 200);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Hold off new beats until every expected result has come
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (pending_setpoints.size() != 0) @(posedge clock);
   endtask

   // Update a joint at a given elapsed time since its start
   task automatic update_at(int j, mode_type mode, logic [31:0] e);
      send_command(OP_UPDATE, j, mode, jt_start_time[j] + e, $urandom, $urandom,
                   $urandom, 16'($urandom));
   endtask

   // ---------------- tests ----------------

   task automatic test_start_stop();
      send_command(OP_UPDATE, 0, MODE_RAMP, 32'd0, 0, 0, 0, 16'd5);
      send_command(OP_START_TARGET, 1, MODE_RAMP, 32'hFFFF_FFFF, 32'sh0001_0000,
                   -32'sh0002_0000, 32'sh0011_0000, 16'd100);
      update_at(1, MODE_RAMP, 32'd50);
      send_command(OP_START_MAG, 2, MODE_NONE, 32'd1000, 32'sh7FFF_FFFF,
                   32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'd65535);
      update_at(2, MODE_RAMP, 32'd65534);
      send_command(OP_STOP, 2, MODE_RAMP, 32'd2000, -32'sh0000_1234, 32'sh55AA_55AA,
                   32'sh1234_5678, 16'd9);
      send_command(OP_START_MAG, 15, MODE_RAMP, 32'd0, -32'sh8000_0000,
                   -32'sh8000_0000, -32'sh8000_0000, 16'd1);
      update_at(15, MODE_RAMP, 32'd0);
   endtask

   task automatic test_special_cases();
      // saturating magnitude in both directions
      send_command(OP_START_TARGET, 3, MODE_RAMP, 32'd7, -32'sh8000_0000, 0,
                   32'sh7FFF_FFFF, 16'd400);
      update_at(3, MODE_RAMP, 32'd399);
      send_command(OP_START_TARGET, 4, MODE_RAMP, 32'd7, 32'sh7FFF_FFFF, 0,
                   -32'sh8000_0000, 16'd400);
      update_at(4, MODE_SINE, 32'd50);
      update_at(4, MODE_SINE, 32'd300);
      // zero period is held as one
      send_command(OP_START_MAG, 5, MODE_RAMP, 32'd100, 32'sh0000_8000, 0,
                   32'sh0100_0000, 16'd0);
      update_at(5, MODE_RAMP, 32'd0);
      update_at(5, MODE_RAMP, 32'd1);
      // elapsed time across the counter wrap, ramp then finished ramp
      send_command(OP_START_MAG, 6, MODE_RAMP, 32'hFFFF_FFF0, 32'sh0010_0000, 0,
                   32'sh0040_0000, 16'd64);
      update_at(6, MODE_RAMP, 32'd20);
      update_at(6, MODE_RAMP, 32'd64);
      update_at(6, MODE_RAMP, 32'hFFFF_FFFF);
      // linear profile both branches, unused mode
      update_at(6, MODE_LINEAR, 32'd10);
      update_at(6, MODE_LINEAR, 32'd40);
      update_at(6, MODE_NONE, 32'd10);
      update_at(6, MODE_SINE, 32'd15);
      update_at(6, MODE_SINE, 32'd16);
   endtask

   task automatic test_random_profiles(int count);
      int          j, r;
      logic [31:0] e;
      logic [15:0] per;
      mode_type    mode;
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) no_idle = ($urandom_range(0, 2) == 0);
         if (n == count / 2) wait_drained();
         j = $urandom_range(0, JOINT_COUNT - 1);
         r = $urandom_range(0, 99);
         if (r < 15) begin
            per = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2000));
            send_command(r < 7 ? OP_START_TARGET : OP_START_MAG, j, MODE_NONE, $urandom,
                         $urandom, $urandom, $urandom, per);
         end else if (r < 20) begin
            send_command(OP_STOP, j, MODE_NONE, $urandom, $urandom, $urandom,
                         $urandom, 16'($urandom));
         end else begin
            mode = ($urandom_range(0, 19) == 0) ? MODE_NONE
                                                : mode_type'($urandom_range(0, 2));
            e = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2 * jt_period[j] + 1)
                                           : $urandom;
            update_at(j, mode, e);
         end
      end
   endtask

   // ---------------- checking ----------------

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin
      setpoint_type exp_sp;
      if (!reset && rsp_valid) begin
         if (pending_setpoints.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result beat pos=%h", $time, rsp_desired_position);
         end else begin
            exp_sp = pending_setpoints.pop_front();
            if (rsp_desired_position !== exp_sp.position) begin
               error_count++;
               $display("%0t: desired_position expected %h actual %h", $time,
                        exp_sp.position, rsp_desired_position);
            end
            if (rsp_desired_velocity !== exp_sp.velocity) begin
               error_count++;
               $display("%0t: desired_velocity expected %h actual %h", $time,
                        exp_sp.velocity, rsp_desired_velocity);
            end
            if (rsp_in_progress !== exp_sp.in_progress) begin
               error_count++;
               $display("%0t: in_progress expected %b actual %b", $time,
                        exp_sp.in_progress, rsp_in_progress);
            end
            if (rsp_drive_cleared !== exp_sp.drive_cleared) begin
               error_count++;
               $display("%0t: drive_cleared expected %b actual %b", $time,
                        exp_sp.drive_cleared, rsp_drive_cleared);
            end
         end
      end
   end

   // ---------------- sequence ----------------

   initial begin
      error_count = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_STOP;
      req_joint_index = '0;
      req_profile_mode = MODE_RAMP;
      req_now_ms = '0;
      req_position_now = '0;
      req_velocity_now = '0;
      req_target_or_magnitude = '0;
      req_period_ms = '0;
      for (int j = 0; j < JOINT_COUNT; j++) begin
         jt_start_time[j] = 0;
         jt_start_pos[j] = 0;
         jt_magnitude[j] = 0;
         jt_period[j] = 16'd1;
         jt_target_pos[j] = 0;
         jt_target_vel[j] = 0;
      end
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_start_stop();
      test_special_cases();
      test_random_profiles(725);

      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_setpoints.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Give up on a hung run
   initial begin
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/jctg_pkg.sv
hw/rtl/jctg_mul_serial.sv
hw/rtl/jctg_div_serial.sv
hw/rtl/jctg_joint_store.sv
hw/rtl/joint_cosine_trajectory_generator_unit.sv
bench/tb_joint_cosine_trajectory_generator_unit.sv
